@@ rtl/core/vcps_pkg.sv @@
`default_nettype none

package vcps_pkg;

   // Payload widths on the stream ports
   localparam int ReqDataWidth = 48;
   localparam int ReqUserWidth = 3;
   localparam int RspDataWidth = 40;

   // Volume limits and control point lengths
   localparam logic [7:0] VolMax   = 8'hFF;
   localparam logic [7:0] VolMin   = 8'h00;
   localparam logic [7:0] CpMinLen = 8'd2;
   localparam logic [7:0] CpAbsLen = 8'd3;
   localparam logic [7:0] StepSizeReset = 8'd1;

   typedef enum logic [2:0] {
      ACT_CP_WRITE    = 3'd0,
      ACT_READ_STATE  = 3'd1,
      ACT_READ_FLAGS  = 3'd2,
      ACT_HOST_STATE  = 3'd3,
      ACT_HOST_FLAGS  = 3'd4
   } action_type;

   typedef enum logic [7:0] {
      OP_REL_DOWN        = 8'd0,
      OP_REL_UP          = 8'd1,
      OP_UNMUTE_REL_DOWN = 8'd2,
      OP_UNMUTE_REL_UP   = 8'd3,
      OP_SET_ABS         = 8'd4,
      OP_UNMUTE          = 8'd5,
      OP_MUTE            = 8'd6
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_BAD_LEN     = 2'd1,
      ST_BAD_COUNTER = 2'd2,
      ST_BAD_OPCODE  = 2'd3
   } status_type;

   // Volume service state
   typedef struct packed {
      logic [7:0] volume;
      logic       muted;
      logic [7:0] count;
      logic [7:0] flags;
   } vol_state_type;

   // Notification flags of one request
   typedef struct packed {
      logic state_changed;
      logic flags_changed;
   } chg_type;

   // Outcome of a control point write
   typedef struct packed {
      status_type status;
      logic       req_valid;
      logic [7:0] req_volume;
      logic       req_mute;
   } cp_result_type;

   // One result item
   typedef struct packed {
      cp_result_type cp;
      vol_state_type st;
      chg_type       chg;
   } rsp_item_type;

endpackage

`default_nettype wire

@@ rtl/core/vcps_cp_check.sv @@
`default_nettype none

module vcps_cp_check (
   input  wire logic                   is_write,
   input  wire vcps_pkg::vol_state_type cur_state,
   input  wire logic [7:0]             vol_step,
   input  wire logic [7:0]             opcode,
   input  wire logic [7:0]             counter_in,
   input  wire logic [7:0]             volume_in,
   input  wire logic [7:0]             write_length,
   input  wire logic                   requester_known,
   output vcps_pkg::cp_result_type     result
);

   logic [8:0] up_sum;
   logic [7:0] vol_up;
   logic [7:0] vol_down;

   // Saturating relative steps
   assign up_sum   = {1'b0, cur_state.volume} + {1'b0, vol_step};
   assign vol_up   = up_sum[8] ? vcps_pkg::VolMax : up_sum[7:0];
   assign vol_down = (cur_state.volume >= vol_step) ? (cur_state.volume - vol_step)
                                                    : vcps_pkg::VolMin;

   // Check length, then counter, then opcode
   always_comb begin
      vcps_pkg::status_type st;
      logic [7:0]           nv;
      logic                 nm;
      st     = vcps_pkg::ST_OK;
      nv     = cur_state.volume;
      nm     = cur_state.muted;
      result = '0;
      if (is_write) begin
         if (write_length < vcps_pkg::CpMinLen) begin
            st = vcps_pkg::ST_BAD_LEN;
         end else if (counter_in != cur_state.count) begin
            st = vcps_pkg::ST_BAD_COUNTER;
         end else begin
            unique case (vcps_pkg::opcode_type'(opcode))
               vcps_pkg::OP_REL_DOWN: begin
                  nv = vol_down;
               end
               vcps_pkg::OP_REL_UP: begin
                  nv = vol_up;
               end
               vcps_pkg::OP_UNMUTE_REL_DOWN: begin
                  nm = 1'b0;
                  nv = vol_down;
               end
               vcps_pkg::OP_UNMUTE_REL_UP: begin
                  nm = 1'b0;
                  nv = vol_up;
               end
               vcps_pkg::OP_SET_ABS: begin
                  if (write_length != vcps_pkg::CpAbsLen) begin
                     st = vcps_pkg::ST_BAD_LEN;
                  end else begin
                     nv = volume_in;
                  end
               end
               vcps_pkg::OP_UNMUTE: begin
                  nm = 1'b0;
               end
               vcps_pkg::OP_MUTE: begin
                  nm = 1'b1;
               end
               default: begin
                  st = vcps_pkg::ST_BAD_OPCODE;
               end
            endcase
         end
         result.status = st;
         if (st == vcps_pkg::ST_OK) begin
            result.req_volume = nv;
            result.req_mute   = nm;
            result.req_valid  = requester_known;
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/vcps_state.sv @@
`default_nettype none

module vcps_state (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    upd_en,
   input  wire logic [2:0]              action,
   input  wire logic [7:0]              volume_in,
   input  wire logic                    mute_in,
   input  wire logic [7:0]              flags_in,
   output vcps_pkg::vol_state_type      cur_state,
   output vcps_pkg::vol_state_type      nxt_state,
   output vcps_pkg::chg_type            chg
);

   vcps_pkg::vol_state_type state_ff;
   vcps_pkg::vol_state_type state_in;

   // Apply host updates that differ from the held state
   always_comb begin
      state_in = state_ff;
      chg      = '0;
      unique case (vcps_pkg::action_type'(action))
         vcps_pkg::ACT_HOST_STATE: begin
            if ((state_ff.volume != volume_in) || (state_ff.muted != mute_in)) begin
               state_in.volume   = volume_in;
               state_in.muted    = mute_in;
               state_in.count    = state_ff.count + 8'd1;
               chg.state_changed = 1'b1;
            end
         end
         vcps_pkg::ACT_HOST_FLAGS: begin
            if (state_ff.flags != flags_in) begin
               state_in.flags    = flags_in;
               chg.flags_changed = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Hold state; advance on an accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (upd_en) begin
         state_ff <= state_in;
      end
   end

   assign cur_state = state_ff;
   assign nxt_state = state_in;

endmodule

`default_nettype wire

@@ rtl/core/volume_control_point_server.sv @@
`default_nettype none

// Channel  | Direction | Ports                        | Contents
// req      | in        | req_tvalid/tready/tdata/tuser| one request: write, read or host update
// rsp      | out       | rsp_tvalid/tready/tdata      | one result per request
// csr      | in        | csr_wr_en/csr_wr_data        | volume step register
//
// One request per cycle while req_tready is high; each result appears in the cycle after its request is accepted.
// The state registers and the result register are the only stages; all
// checks and the saturating step sit between them.
// Reset clears volume, mute, counter and flags to zero and the volume step to 1.
// A stalled result holds in the result register; req_tready drops only
// while that register is full and rsp_tready is low.

module volume_control_point_server (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // opcode[7:0], counter_in[15:8], volume_in[23:16], write_length[31:24],
   // mute_in[32], flags_in[40:33], requester_known[41], zero[47:42]
   input  wire logic [vcps_pkg::ReqDataWidth-1:0] req_tdata,
   // action[2:0]
   input  wire logic [vcps_pkg::ReqUserWidth-1:0] req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // status[1:0], request_valid[2], requested_volume[10:3], requested_mute[11],
   // volume_out[19:12], mute_out[20], counter_out[28:21], flags_out[36:29],
   // state_changed[37], flags_changed[38], zero[39]
   output logic [vcps_pkg::RspDataWidth-1:0]      rsp_tdata,
   input  wire logic                              csr_wr_en,
   input  wire logic [7:0]                        csr_wr_data
);

   logic       req_fire;
   logic [7:0] opcode;
   logic [7:0] counter_in;
   logic [7:0] volume_in;
   logic [7:0] write_length;
   logic       mute_in;
   logic [7:0] flags_in;
   logic       requester_known;
   logic       is_write;

   logic [7:0] vol_step_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   vcps_pkg::rsp_item_type rsp_item_ff;
   vcps_pkg::rsp_item_type rsp_item_in;

   vcps_pkg::vol_state_type cur_state;
   vcps_pkg::vol_state_type nxt_state;
   vcps_pkg::chg_type       chg;
   vcps_pkg::cp_result_type cp_result;

   // Unpack the request
   assign opcode          = req_tdata[7:0];
   assign counter_in      = req_tdata[15:8];
   assign volume_in       = req_tdata[23:16];
   assign write_length    = req_tdata[31:24];
   assign mute_in         = req_tdata[32];
   assign flags_in        = req_tdata[40:33];
   assign requester_known = req_tdata[41];
   assign is_write        = (vcps_pkg::action_type'(req_tuser) == vcps_pkg::ACT_CP_WRITE);

   // Accept while the result register is empty or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   // Step size register
   always_ff @(posedge clock) begin
      if (reset) begin
         vol_step_ff <= vcps_pkg::StepSizeReset;
      end else if (csr_wr_en) begin
         vol_step_ff <= csr_wr_data;
      end
   end

   vcps_state u_state (
      .clock     (clock),
      .reset     (reset),
      .upd_en    (req_fire),
      .action    (req_tuser),
      .volume_in (volume_in),
      .mute_in   (mute_in),
      .flags_in  (flags_in),
      .cur_state (cur_state),
      .nxt_state (nxt_state),
      .chg       (chg)
   );

   vcps_cp_check u_cp_check (
      .is_write        (is_write),
      .cur_state       (cur_state),
      .vol_step        (vol_step_ff),
      .opcode          (opcode),
      .counter_in      (counter_in),
      .volume_in       (volume_in),
      .write_length    (write_length),
      .requester_known (requester_known),
      .result          (cp_result)
   );

   // Load the result register on accept, drop it when taken
   always_comb begin
      rsp_item_in    = rsp_item_ff;
      rsp_valid_in   = rsp_valid_ff;
      if (req_fire) begin
         rsp_item_in.cp  = cp_result;
         rsp_item_in.st  = nxt_state;
         rsp_item_in.chg = chg;
         rsp_valid_in    = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   // Pack the result, first field lowest
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0,
                        rsp_item_ff.chg.flags_changed,
                        rsp_item_ff.chg.state_changed,
                        rsp_item_ff.st.flags,
                        rsp_item_ff.st.count,
                        rsp_item_ff.st.muted,
                        rsp_item_ff.st.volume,
                        rsp_item_ff.cp.req_mute,
                        rsp_item_ff.cp.req_volume,
                        rsp_item_ff.cp.req_valid,
                        rsp_item_ff.cp.status};

   // The change counter only ever advances by one
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (cur_state.count != $past(cur_state.count)))
      |-> (cur_state.count == $past(cur_state.count) + 8'd1))
      else $error("change counter jumped");

   // A change request only comes with a successful status
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.cp.req_valid)
      |-> (rsp_item_ff.cp.status == vcps_pkg::ST_OK))
      else $error("request_valid with failed status");

   // One request never raises both notifications
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_item_ff.chg.state_changed && rsp_item_ff.chg.flags_changed))
      else $error("both notifications raised");

   // Never accept over a stalled result
   assert property (@(posedge clock) disable iff (reset)
      !(req_fire && rsp_valid_ff && !rsp_tready))
      else $error("result overwritten while stalled");

   // A host flags update leaves the new flags in state
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && (vcps_pkg::action_type'(req_tuser) == vcps_pkg::ACT_HOST_FLAGS))
      |=> (cur_state.flags == $past(flags_in)))
      else $error("flags update lost");

endmodule

`default_nettype wire

@@ test/volume_control_point_server_test.sv @@
module volume_control_point_server_test;
   import vcps_pkg::*;

   localparam int WatchdogLimit  = 1000;
   localparam int LongHoldCycles = 40;
   localparam int PhaseRequests  = 245;

   // Action codes the block ignores, and the first opcode it rejects
   localparam logic [2:0] ActUnusedLo        = 3'd5;
   localparam logic [2:0] ActUnusedHi        = 3'd7;
   localparam logic [7:0] OpFirstUnsupported = 8'd7;

   typedef struct {
      logic [2:0] action;
      logic [7:0] opcode;
      logic [7:0] counter;
      logic [7:0] volume;
      logic [7:0] wr_len;
      logic       mute;
      logic [7:0] flags;
      logic       known;
   } vol_request_t;

   typedef struct {
      status_type status;
      logic       req_valid;
      logic [7:0] req_volume;
      logic       req_mute;
      logic [7:0] volume;
      logic       muted;
      logic [7:0] count;
      logic [7:0] flags;
      logic       state_changed;
      logic       flags_changed;
   } vol_response_t;

   // Volume service model: tracks state, predicts and checks each response
   class vol_scoreboard;
      logic [7:0] step;
      logic [7:0] volume;
      logic       muted;
      logic [7:0] count;
      logic [7:0] flags;
      vol_response_t awaited_responses[$];
      int mismatch_count;

      function new();
         step = StepSizeReset;
         volume = VolMin;
         muted = 1'b0;
         count = 8'd0;
         flags = 8'd0;
         mismatch_count = 0;
      endfunction

      function logic [7:0] lowered(logic [7:0] v);
         return (v >= step) ? v - step : VolMin;
      endfunction

      function logic [7:0] raised(logic [7:0] v);
         return (v <= VolMax - step) ? v + step : VolMax;
      endfunction

      // Apply one accepted request and queue the response it must produce
      function void predict_request(vol_request_t r);
         vol_response_t want;
         logic [7:0] next_vol;
         logic       next_mute;
         want.status = ST_OK;
         want.req_valid = 1'b0;
         want.req_volume = 8'd0;
         want.req_mute = 1'b0;
         want.state_changed = 1'b0;
         want.flags_changed = 1'b0;
         next_vol = volume;
         next_mute = muted;
         case (r.action)
            ACT_CP_WRITE: begin
               // length first, then counter, then opcode
               if (r.wr_len < CpMinLen) begin
                  want.status = ST_BAD_LEN;
               end else if (r.counter != count) begin
                  want.status = ST_BAD_COUNTER;
               end else begin
                  case (r.opcode)
                     OP_REL_DOWN: next_vol = lowered(volume);
                     OP_REL_UP: next_vol = raised(volume);
                     OP_UNMUTE_REL_DOWN: begin
                        next_mute = 1'b0;
                        next_vol = lowered(volume);
                     end
                     OP_UNMUTE_REL_UP: begin
                        next_mute = 1'b0;
                        next_vol = raised(volume);
                     end
                     OP_SET_ABS: begin
                        if (r.wr_len != CpAbsLen) want.status = ST_BAD_LEN;
                        else next_vol = r.volume;
                     end
                     OP_UNMUTE: next_mute = 1'b0;
                     OP_MUTE: next_mute = 1'b1;
                     default: want.status = ST_BAD_OPCODE;
                  endcase
                  if (want.status == ST_OK) begin
                     want.req_volume = next_vol;
                     want.req_mute = next_mute;
                     want.req_valid = r.known;
                  end
               end
            end
            ACT_HOST_STATE: begin
               if (r.volume != volume || r.mute != muted) begin
                  volume = r.volume;
                  muted = r.mute;
                  count = count + 8'd1;
                  want.state_changed = 1'b1;
               end
            end
            ACT_HOST_FLAGS: begin
               if (r.flags != flags) begin
                  flags = r.flags;
                  want.flags_changed = 1'b1;
               end
            end
            default: ;
         endcase
         want.volume = volume;
         want.muted = muted;
         want.count = count;
         want.flags = flags;
         awaited_responses.push_back(want);
      endfunction

      // Compare one accepted response with the oldest prediction
      function void check_response(logic [RspDataWidth-1:0] d);
         vol_response_t got;
         vol_response_t want;
         got.status = status_type'(d[1:0]);
         got.req_valid = d[2];
         got.req_volume = d[10:3];
         got.req_mute = d[11];
         got.volume = d[19:12];
         got.muted = d[20];
         got.count = d[28:21];
         got.flags = d[36:29];
         got.state_changed = d[37];
         got.flags_changed = d[38];
         if (awaited_responses.size() == 0) begin
            if (mismatch_count < 10)
               $display("%0t: response with no request pending: %h", $realtime, d);
            mismatch_count++;
            return;
         end
         want = awaited_responses.pop_front();
         if (got.status !== want.status || got.req_valid !== want.req_valid ||
             got.req_volume !== want.req_volume || got.req_mute !== want.req_mute ||
             got.volume !== want.volume || got.muted !== want.muted ||
             got.count !== want.count || got.flags !== want.flags ||
             got.state_changed !== want.state_changed ||
             got.flags_changed !== want.flags_changed) begin
            if (mismatch_count < 10) begin
               $display("%0t: response mismatch (status rv rvol rmute vol mute cnt flg sc fc)",
                        $realtime);
               $display("   expected %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                        want.status, want.req_valid, want.req_volume, want.req_mute,
                        want.volume, want.muted, want.count, want.flags,
                        want.state_changed, want.flags_changed);
               $display("   actual   %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                        got.status, got.req_valid, got.req_volume, got.req_mute,
                        got.volume, got.muted, got.count, got.flags,
                        got.state_changed, got.flags_changed);
            end
            mismatch_count++;
         end
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   // opcode, counter_in, volume_in, write_length, mute_in, flags_in, requester_known
   logic [ReqDataWidth-1:0] req_tdata;
   // action
   logic [ReqUserWidth-1:0] req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   // status, request_valid, requested_volume, requested_mute, volume_out,
   // mute_out, counter_out, flags_out, state_changed, flags_changed
   logic [RspDataWidth-1:0] rsp_tdata;
   logic                    csr_wr_en;
   logic [7:0]              csr_wr_data;

   vol_scoreboard sb = new();
   int  quiet_cycles = 0;
   bit  req_idle_on = 1'b1;
   bit  rsp_idle_on = 1'b1;
   bit  long_hold_pending = 1'b0;

   volume_control_point_server dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Check responses and watch for a stalled run
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Drive rsp_tready: long hold on demand, random stall bursts, ready stretches
   initial begin
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LongHoldCycles) @(posedge clock);
         end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : 1)
               @(posedge clock);
         end
      end
   end

   function automatic vol_request_t make_request(logic [2:0] action, logic [7:0] opcode,
                                                 logic [7:0] counter, logic [7:0] volume,
                                                 logic [7:0] wr_len, logic mute,
                                                 logic [7:0] flags, logic known);
      vol_request_t r;
      r.action = action;
      r.opcode = opcode;
      r.counter = counter;
      r.volume = volume;
      r.wr_len = wr_len;
      r.mute = mute;
      r.flags = flags;
      r.known = known;
      return r;
   endfunction

   // Mostly well-formed writes and host updates, some reads and noise
   function automatic vol_request_t random_request();
      vol_request_t r;
      int pick;
      pick = $urandom_range(0, 99);
      r.action = ACT_CP_WRITE;
      r.opcode = 8'($urandom);
      r.counter = 8'($urandom);
      r.volume = 8'($urandom);
      r.wr_len = 8'($urandom);
      r.mute = 1'($urandom);
      r.flags = 8'($urandom);
      r.known = ($urandom_range(0, 4) != 0);
      if (pick < 55) begin
         if ($urandom_range(0, 9) != 0) r.counter = sb.count;
         if ($urandom_range(0, 15) != 0)
            r.opcode = 8'($urandom_range(OP_REL_DOWN, OP_MUTE));
         if (r.opcode == OP_SET_ABS) begin
            if ($urandom_range(0, 5) != 0) r.wr_len = CpAbsLen;
         end else if ($urandom_range(0, 2) != 0) begin
            r.wr_len = CpMinLen;
         end
      end else if (pick < 77) begin
         r.action = ACT_HOST_STATE;
         if ($urandom_range(0, 9) == 0) begin
            r.volume = sb.volume;
            r.mute = sb.muted;
         end else if ($urandom_range(0, 7) == 0) begin
            r.volume = $urandom_range(0, 1) ? VolMax : VolMin;
         end
      end else if (pick < 85) begin
         r.action = ACT_HOST_FLAGS;
         if ($urandom_range(0, 4) == 0) r.flags = sb.flags;
      end else if (pick < 92) begin
         r.action = $urandom_range(0, 1) ? ACT_READ_STATE : ACT_READ_FLAGS;
      end else begin
         r.action = 3'($urandom_range(0, 7));
      end
      return r;
   endfunction

   // Offer one request and hold it until accepted
   task automatic offer_request(vol_request_t r);
      req_tvalid <= 1'b1;
      req_tuser <= r.action;
      req_tdata <= {6'd0, r.known, r.flags, r.mute, r.wr_len, r.volume, r.counter, r.opcode};
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.predict_request(r);
   endtask

   // Stop offering and wait until every response has come back
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (sb.awaited_responses.size() != 0) @(posedge clock);
   endtask

   task automatic write_step(logic [7:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      sb.step = value;
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      logic [7:0] step_plan [5];
      step_plan[0] = VolMax;
      step_plan[1] = 8'd1;
      step_plan[2] = 8'($urandom_range(2, 254));
      step_plan[3] = 8'd128;
      step_plan[4] = 8'($urandom_range(2, 254));

      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= '0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset state, error precedence, each opcode, saturation
      offer_request(make_request(ACT_READ_STATE, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0));
      offer_request(make_request(ACT_READ_FLAGS, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF,
                                 1'b1));
      offer_request(make_request(ACT_CP_WRITE, OP_REL_UP, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b1));
      offer_request(make_request(ACT_CP_WRITE, OP_REL_UP, 8'h55, 8'd0, 8'd1, 1'b0, 8'd0, 1'b1));
      offer_request(make_request(ACT_CP_WRITE, 8'hFF, 8'd9, 8'd0, CpMinLen, 1'b0, 8'd0, 1'b1));
      offer_request(make_request(ACT_CP_WRITE, OpFirstUnsupported, 8'd0, 8'd0, CpMinLen, 1'b0,
                                 8'd0, 1'b1));
      offer_request(make_request(ACT_CP_WRITE, 8'hFF, 8'd0, 8'd0, 8'hFF, 1'b0, 8'd0, 1'b1));
      offer_request(make_request(ACT_CP_WRITE, OP_REL_DOWN, 8'd0, 8'd0, CpMinLen, 1'b0, 8'd0,
                                 1'b1));
      offer_request(make_request(ACT_CP_WRITE, OP_REL_UP, 8'd0, 8'd0, 8'hFF, 1'b0, 8'd0, 1'b1));
      offer_request(make_request(ACT_CP_WRITE, OP_UNMUTE_REL_DOWN, 8'd0, 8'd0, CpMinLen, 1'b1,
                                 8'd0, 1'b1));
      offer_request(make_request(ACT_CP_WRITE, OP_UNMUTE_REL_UP, 8'd0, 8'd0, CpMinLen, 1'b1,
                                 8'd0, 1'b1));
      offer_request(make_request(ACT_CP_WRITE, OP_SET_ABS, 8'd0, VolMax, CpAbsLen, 1'b0, 8'd0,
                                 1'b1));
      offer_request(make_request(ACT_CP_WRITE, OP_SET_ABS, 8'd0, 8'd77, CpMinLen, 1'b0, 8'd0,
                                 1'b1));
      offer_request(make_request(ACT_CP_WRITE, OP_SET_ABS, 8'd0, 8'd77, 8'hFF, 1'b0, 8'd0,
                                 1'b1));
      offer_request(make_request(ACT_CP_WRITE, OP_UNMUTE, 8'd0, 8'd0, CpMinLen, 1'b0, 8'd0,
                                 1'b1));
      offer_request(make_request(ACT_CP_WRITE, OP_MUTE, 8'd0, 8'd0, CpMinLen, 1'b0, 8'd0, 1'b1));
      offer_request(make_request(ACT_CP_WRITE, OP_REL_UP, 8'd0, 8'd0, 8'hFF, 1'b0, 8'd0, 1'b0));
      offer_request(make_request(ACT_HOST_STATE, 8'd0, 8'd0, VolMax, 8'd0, 1'b1, 8'd0, 1'b0));
      offer_request(make_request(ACT_HOST_STATE, 8'd0, 8'd0, VolMax, 8'd0, 1'b1, 8'd0, 1'b0));
      offer_request(make_request(ACT_CP_WRITE, OP_REL_UP, 8'd1, 8'd0, CpMinLen, 1'b0, 8'd0,
                                 1'b1));
      offer_request(make_request(ACT_HOST_FLAGS, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'hFF, 1'b0));
      offer_request(make_request(ACT_HOST_FLAGS, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'hFF, 1'b0));
      offer_request(make_request(ActUnusedLo, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'h00, 1'b1));
      offer_request(make_request(ActUnusedHi, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF, 1'b1));
      offer_request(make_request(ACT_HOST_STATE, 8'd0, 8'd0, VolMin, 8'd0, 1'b0, 8'd0, 1'b0));

      // Random phases, each under its own step size; no idling in the last one
      for (int phase = 0; phase < 5; phase++) begin
         wait_drain();
         repeat (3) @(posedge clock);
         write_step(step_plan[phase]);
         req_idle_on = (phase != 4);
         rsp_idle_on = (phase != 4);
         if (phase == 2) begin
            // fill the block while the response side holds off
            long_hold_pending = 1'b1;
            repeat (30) offer_request(random_request());
            wait_drain();
         end
         for (int i = 0; i < PhaseRequests; i++) begin
            if (req_idle_on && (i % 100) < 70 && $urandom_range(0, 7) == 0) begin
               req_tvalid <= 1'b0;
               repeat ($urandom_range(1, 14)) @(posedge clock);
            end
            offer_request(random_request());
         end
      end

      wait_drain();
      repeat (4) @(posedge clock);
      if (sb.mismatch_count == 0 && sb.awaited_responses.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
